/* hw/rtl/fcsb_pkg.sv */
// frustum cull package: widths, plane count, action codes and item types
// no dependencies; used by the interfaces, the cell and the top level
package fcsb_pkg;

	localparam int PLANE_COUNT = 6;
	localparam int CFG_IDX_W   = 3;
	localparam int PLANE_W     = 64;
	localparam int COORD_W     = 16;
	localparam int RAD_W       = 15;
	localparam int FRAC_BITS   = 14;
	localparam int PROD_W      = 2 * COORD_W;
	localparam int OFS_W       = COORD_W + 1;
	localparam int SUM_W       = PROD_W + 5;

	typedef enum logic {
		ACT_SPHERE = 1'b0,
		ACT_BOX    = 1'b1
	} fcsb_action_t;

	typedef struct packed {
		fcsb_action_t               action;
		logic signed [COORD_W-1:0] x_a;
		logic signed [COORD_W-1:0] y_a;
		logic signed [COORD_W-1:0] z_a;
		logic signed [COORD_W-1:0] x_b;
		logic signed [COORD_W-1:0] y_b;
		logic signed [COORD_W-1:0] z_b;
		logic        [RAD_W-1:0]   radius;
	} fcsb_item_t;

	// what one cell hands to the next
	typedef struct packed {
		logic       valid;
		logic       vis;
		fcsb_item_t item;
	} fcsb_link_t;

endpackage

/* hw/rtl/fcsb_ifs.sv */
// frustum cull channel interfaces: request, result and configuration write
// depends on fcsb_pkg
interface fcsb_req_if;
	logic                valid;
	logic                ready;
	fcsb_pkg::fcsb_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface fcsb_rsp_if;
	logic valid;
	logic ready;
	logic visible;

	modport source (output valid, output visible, input ready);
	modport sink (input valid, input visible, output ready);
endinterface

interface fcsb_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [fcsb_pkg::CFG_IDX_W-1:0] idx;
	logic [fcsb_pkg::PLANE_W-1:0]   data;

	modport source (output valid, output idx, output data, input ready);
	modport sink (input valid, input idx, input data, output ready);
endinterface

/* hw/rtl/fcsb_cell.sv */
// frustum cull cell: holds one plane, tests the passing item against it in two stages
// depends on fcsb_pkg
module fcsb_cell (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic [fcsb_pkg::CFG_IDX_W-1:0] cell_idx,
	input  logic                             en,
	input  logic                             cfg_valid,
	input  logic [fcsb_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [fcsb_pkg::PLANE_W-1:0]   cfg_data,
	input  fcsb_pkg::fcsb_link_t            link_i,
	output fcsb_pkg::fcsb_link_t            link_o
);

	logic [fcsb_pkg::PLANE_W-1:0] plane_q;

	logic signed [fcsb_pkg::COORD_W-1:0] nx, ny, nz, d;
	logic signed [fcsb_pkg::COORD_W-1:0] px, py, pz;
	logic signed [fcsb_pkg::OFS_W-1:0]   ofs;
	logic                                box;

	logic                                valid_s1, vis_s1;
	fcsb_pkg::fcsb_item_t                item_s1;
	logic signed [fcsb_pkg::PROD_W-1:0]  prod_x_s1, prod_y_s1, prod_z_s1;
	logic signed [fcsb_pkg::OFS_W-1:0]   ofs_s1;

	logic signed [fcsb_pkg::SUM_W-1:0]   sum;

	logic                                valid_s2, vis_s2;
	fcsb_pkg::fcsb_item_t                item_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plane_q <= '0;
		end else if (cfg_valid && cfg_idx == cell_idx) begin
			plane_q <= cfg_data;
		end
	end

	assign nx = signed'(plane_q[15:0]);
	assign ny = signed'(plane_q[31:16]);
	assign nz = signed'(plane_q[47:32]);
	assign d  = signed'(plane_q[63:48]);

	// positive vertex for a box, center for a sphere
	always_comb begin
		box = (link_i.item.action == fcsb_pkg::ACT_BOX);
		px  = (box && !nx[fcsb_pkg::COORD_W-1]) ? link_i.item.x_b : link_i.item.x_a;
		py  = (box && !ny[fcsb_pkg::COORD_W-1]) ? link_i.item.y_b : link_i.item.y_a;
		pz  = (box && !nz[fcsb_pkg::COORD_W-1]) ? link_i.item.z_b : link_i.item.z_a;
		// radius folds into the offset: n.c + (d + r) * 2^14 < 0
		ofs = fcsb_pkg::OFS_W'(d);
		if (!box) begin
			ofs = fcsb_pkg::OFS_W'(d) + signed'({2'b00, link_i.item.radius});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= link_i.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_s1   <= link_i.item;
			vis_s1    <= link_i.vis;
			prod_x_s1 <= nx * px;
			prod_y_s1 <= ny * py;
			prod_z_s1 <= nz * pz;
			ofs_s1    <= ofs;
		end
	end

	assign sum = fcsb_pkg::SUM_W'(prod_x_s1) + fcsb_pkg::SUM_W'(prod_y_s1)
		+ fcsb_pkg::SUM_W'(prod_z_s1) + (fcsb_pkg::SUM_W'(ofs_s1) <<< fcsb_pkg::FRAC_BITS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_s2 <= item_s1;
			vis_s2  <= vis_s1 & ~sum[fcsb_pkg::SUM_W-1];
		end
	end

	assign link_o = '{valid: valid_s2, vis: vis_s2, item: item_s2};

endmodule

/* hw/rtl/frustum_cull_sphere_box.sv */
// frustum cull top level: a row of plane cells between request and result channels
// depends on fcsb_pkg, fcsb_ifs and fcsb_cell
//
// req carries one sphere (action 0: center in x_a/y_a/z_a, radius) or one
// axis-aligned box (action 1: minimum in *_a, maximum in *_b) per item.
// rsp returns one visible bit per item, in order.
// cfg writes plane register idx (0 left .. 5 far); it is always ready and
// indexes 6 and 7 are dropped. Each register packs nx, ny, nz (Q1.14) and d.
// Each plane has a cell of two stages: three 16x16 products, then their sum
// with the offset and a sign test; the item and its running visible bit move
// through both stages of each cell in turn, cell by cell, to rsp. While rsp
// is not stalled a new item is taken every cycle, since each of the 12
// stages holds one item.
// When rsp is stalled with a result waiting, the whole row holds and req.ready
// falls; it rises again in the cycle the result is taken.
// Reset clears all planes to zero (every volume visible) and empties the row.
module frustum_cull_sphere_box (
	input logic  clk,
	input logic  arst_n,
	fcsb_req_if.sink   req,
	fcsb_rsp_if.source rsp,
	fcsb_cfg_if.sink   cfg
);

	fcsb_pkg::fcsb_link_t link [fcsb_pkg::PLANE_COUNT+1];
	logic                 en;

	assign en        = !rsp.valid || rsp.ready;
	assign req.ready = en;
	assign cfg.ready = 1'b1;

	assign link[0] = '{valid: req.valid, vis: 1'b1, item: req.data};

	for (genvar k = 0; k < fcsb_pkg::PLANE_COUNT; k++) begin : g_cell
		fcsb_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.cell_idx  (fcsb_pkg::CFG_IDX_W'(k)),
			.en        (en),
			.cfg_valid (cfg.valid),
			.cfg_idx   (cfg.idx),
			.cfg_data  (cfg.data),
			.link_i    (link[k]),
			.link_o    (link[k+1])
		);
	end

	assign rsp.valid   = link[fcsb_pkg::PLANE_COUNT].valid;
	assign rsp.visible = link[fcsb_pkg::PLANE_COUNT].vis;

endmodule

/* hw/rtl/fcsb_checker.sv */
// frustum cull port checker and its bind to the top level
// depends on frustum_cull_sphere_box's ports only
module fcsb_checker (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_ready,
	input logic rsp_valid,
	input logic rsp_ready,
	input logic rsp_visible,
	input logic cfg_ready
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_visible))
		else $error("result changed while stalled");

	a_req_ready: assert property (@(posedge clk) disable iff (!arst_n)
		req_ready == (!rsp_valid || rsp_ready))
		else $error("req ready does not follow result stall");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready)
		else $error("cfg write not taken");

	a_stall_no_take: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready && req_valid |-> !req_ready)
		else $error("item taken while result stalled");

endmodule

bind frustum_cull_sphere_box fcsb_checker u_fcsb_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.req_valid   (req.valid),
	.req_ready   (req.ready),
	.rsp_valid   (rsp.valid),
	.rsp_ready   (rsp.ready),
	.rsp_visible (rsp.visible),
	.cfg_ready   (cfg.ready)
);
